// ----- design/json_string_unescape_utf8_macros.svh -----
// Assertion macros used by the checker of the string unescaper.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/jsu_pkg.sv -----
package jsu_pkg;

  // Scanner modes.
  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_ESC,
    MODE_HEX,
    MODE_PEND,
    MODE_PEND_ESC
  } mode_t;

  // Error codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_ESC   = 3'd1;
  localparam logic [2:0] ERR_BAD_HEX   = 3'd2;
  localparam logic [2:0] ERR_TRUNC_HEX = 3'd3;
  localparam logic [2:0] ERR_UNTERM    = 3'd4;

  // Characters with a meaning in the string body.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  // Control characters produced by the simple escapes.
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  // Surrogate ranges and UTF-8 lead and continuation marks.
  localparam logic [15:0] SURR_HI_MIN = 16'hD800;
  localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
  localparam logic [5:0]  SURR_HI_TAG = 6'b110110;
  localparam logic [20:0] CP_2BYTE    = 21'h80;
  localparam logic [20:0] CP_3BYTE    = 21'h800;
  localparam logic [20:0] CP_4BYTE    = 21'h10000;
  localparam logic [7:0]  UTF8_CONT   = 8'h80;
  localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
  localparam logic [7:0]  UTF8_LEAD4  = 8'hF0;

  // One result item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       string_done;
    logic [2:0] error_code;
  } res_t;

  // A short run of results (up to four) with its length.
  typedef struct packed {
    res_t [3:0] res;
    logic [2:0] n;
  } enc_t;

  function automatic res_t byte_res(input logic [7:0] b);
    res_t r;
    r = '0;
    r.data_byte  = b;
    r.byte_valid = 1'b1;
    return r;
  endfunction

  function automatic enc_t one_res(input res_t r);
    enc_t e;
    e = '0;
    e.res[0] = r;
    e.n      = 3'd1;
    return e;
  endfunction

  function automatic enc_t err_res(input logic [2:0] code);
    res_t r;
    r = '0;
    r.error_code = code;
    return one_res(r);
  endfunction

  // UTF-8 encoding of a code point of up to 21 bits.
  function automatic enc_t utf8_enc(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < CP_2BYTE) begin
      e.res[0] = byte_res(cp[7:0]);
      e.n      = 3'd1;
    end else if (cp < CP_3BYTE) begin
      e.res[0] = byte_res(UTF8_LEAD2 | {3'b000, cp[10:6]});
      e.res[1] = byte_res(UTF8_CONT | {2'b00, cp[5:0]});
      e.n      = 3'd2;
    end else if (cp < CP_4BYTE) begin
      e.res[0] = byte_res(UTF8_LEAD3 | {4'b0000, cp[15:12]});
      e.res[1] = byte_res(UTF8_CONT | {2'b00, cp[11:6]});
      e.res[2] = byte_res(UTF8_CONT | {2'b00, cp[5:0]});
      e.n      = 3'd3;
    end else begin
      e.res[0] = byte_res(UTF8_LEAD4 | {5'b00000, cp[20:18]});
      e.res[1] = byte_res(UTF8_CONT | {2'b00, cp[17:12]});
      e.res[2] = byte_res(UTF8_CONT | {2'b00, cp[11:6]});
      e.res[3] = byte_res(UTF8_CONT | {2'b00, cp[5:0]});
      e.n      = 3'd4;
    end
    return e;
  endfunction

  // Hex digit decode: bit 4 flags a valid digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] d;
    d = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = {1'b1, 4'(b - 8'h37)};
    end
    return d;
  endfunction

  // Simple escape decode: bit 8 flags a known escape letter.
  function automatic logic [8:0] esc_char(input logic [7:0] b);
    logic [8:0] c;
    case (b)
      CH_QUOTE:  c = {1'b1, CH_QUOTE};
      CH_BSLASH: c = {1'b1, CH_BSLASH};
      CH_SLASH:  c = {1'b1, CH_SLASH};
      CH_LOW_B:  c = {1'b1, CTL_BS};
      CH_LOW_F:  c = {1'b1, CTL_FF};
      CH_LOW_N:  c = {1'b1, CTL_LF};
      CH_LOW_R:  c = {1'b1, CTL_CR};
      CH_LOW_T:  c = {1'b1, CTL_HT};
      default:   c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- design/json_string_unescape_utf8.sv -----
// JSON string body unescaper with UTF-8 output.
// Input channel: one byte of the string body per transfer (after the opening
// quote), or an end-of-text marker. Result channel: decoded UTF-8 bytes, a
// string-done marker on the closing quote, or an error code; out_last marks
// the final result that belongs to one input transfer.
// One input byte yields zero to six results. The byte is held in an input
// register, decoded combinationally, and its results are loaded one per cycle
// into the output register while the receiver accepts; the first result passes
// the holding register, then the output register. Single-result items flow at
// one per cycle while the receiver accepts; an item with n results takes n loads.
// Items without a result (a backslash, a hex digit) retire without an output load.
// A two-entry input stage (holding register plus skid register) keeps
// in_ready registered, so a new byte is taken while a result still waits.
// When the receiver stalls, the output register holds its result, the
// current byte waits, and in_ready drops once the skid register fills.
// Reset (rst_n low at a clock edge) empties both stages and returns the
// scanner to normal text mode with no pending surrogate.
module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic       out_byte_valid,
  output logic       out_string_done,
  output logic [2:0] out_error_code,
  output logic       out_last
);
  import jsu_pkg::*;

  // Input stage registers.
  logic       main_v_r, skid_v_r;
  logic [7:0] main_byte_r, skid_byte_r;
  logic       main_eot_r, skid_eot_r;

  // Scanner state.
  mode_t       mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [9:0]  ph_r, ph_nxt;
  logic        pv_r, pv_nxt;

  // Output stage.
  res_t       out_r;
  logic       out_valid_r, out_last_r;
  logic [2:0] idx_r;

  // Decode results.
  logic       flush;
  enc_t       tail, pend_enc;
  res_t [5:0] ent;
  logic [2:0] n_items, last_idx;
  logic       in_fire, out_load, consume, main_free;

  // Decode of the held byte against the scanner state.
  always_comb begin
    logic        do_text, do_esc;
    logic [4:0]  dig;
    logic [8:0]  ec;
    logic [15:0] acc_new;
    logic [2:0]  cnt_new;
    flush    = 1'b0;
    tail     = '0;
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    ph_nxt   = ph_r;
    pv_nxt   = pv_r;
    do_text  = 1'b0;
    do_esc   = 1'b0;
    dig      = hex_digit(main_byte_r);
    ec       = esc_char(main_byte_r);
    acc_new  = {acc_r[11:0], dig[3:0]};
    cnt_new  = 3'(cnt_r + 3'd1);
    pend_enc = utf8_enc({5'd0, SURR_HI_TAG, ph_r});

    if (main_eot_r) begin
      // End of text: flush a held high surrogate, then report.
      flush    = pv_r;
      tail     = err_res((mode_r == MODE_HEX) ? ERR_TRUNC_HEX : ERR_UNTERM);
      mode_nxt = MODE_NORMAL;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      ph_nxt   = '0;
      pv_nxt   = 1'b0;
    end else begin
      case (mode_r)
        MODE_ESC: begin
          do_esc = 1'b1;
        end
        MODE_PEND: begin
          if (main_byte_r == CH_BSLASH) begin
            mode_nxt = MODE_PEND_ESC;
          end else begin
            flush   = pv_r;
            ph_nxt  = '0;
            pv_nxt  = 1'b0;
            do_text = 1'b1;
          end
        end
        MODE_PEND_ESC: begin
          if (main_byte_r == CH_LOW_U) begin
            mode_nxt = MODE_HEX;
            acc_nxt  = '0;
            cnt_nxt  = '0;
          end else begin
            flush  = pv_r;
            ph_nxt = '0;
            pv_nxt = 1'b0;
            do_esc = 1'b1;
          end
        end
        MODE_HEX: begin
          if (!dig[4]) begin
            flush    = pv_r;
            tail     = err_res(ERR_BAD_HEX);
            mode_nxt = MODE_NORMAL;
            acc_nxt  = '0;
            cnt_nxt  = '0;
            ph_nxt   = '0;
            pv_nxt   = 1'b0;
          end else begin
            acc_nxt = acc_new;
            cnt_nxt = cnt_new;
            if (cnt_new >= 3'd4) begin
              // Fourth digit: the code unit is complete.
              mode_nxt = MODE_NORMAL;
              acc_nxt  = '0;
              cnt_nxt  = '0;
              if (pv_r && acc_new >= SURR_LO_MIN && acc_new <= SURR_LO_MAX) begin
                tail   = utf8_enc(CP_4BYTE + {1'b0, ph_r, acc_new[9:0]});
                ph_nxt = '0;
                pv_nxt = 1'b0;
              end else begin
                flush  = pv_r;
                ph_nxt = '0;
                pv_nxt = 1'b0;
                if (acc_new >= SURR_HI_MIN && acc_new <= SURR_HI_MAX) begin
                  ph_nxt   = acc_new[9:0];
                  pv_nxt   = 1'b1;
                  mode_nxt = MODE_PEND;
                end else begin
                  tail = utf8_enc({5'd0, acc_new});
                end
              end
            end
          end
        end
        default: begin
          do_text = 1'b1;
        end
      endcase
    end

    // Plain text byte.
    if (do_text) begin
      mode_nxt = MODE_NORMAL;
      if (main_byte_r == CH_QUOTE) begin
        tail          = '0;
        tail.res[0].string_done = 1'b1;
        tail.n        = 3'd1;
        acc_nxt       = '0;
        cnt_nxt       = '0;
        ph_nxt        = '0;
        pv_nxt        = 1'b0;
      end else if (main_byte_r == CH_BSLASH) begin
        mode_nxt = MODE_ESC;
      end else begin
        tail = one_res(byte_res(main_byte_r));
      end
    end

    // Byte after a backslash.
    if (do_esc) begin
      mode_nxt = MODE_NORMAL;
      if (main_byte_r == CH_LOW_U) begin
        mode_nxt = MODE_HEX;
        acc_nxt  = '0;
        cnt_nxt  = '0;
      end else if (ec[8]) begin
        tail = one_res(byte_res(ec[7:0]));
      end else begin
        tail    = err_res(ERR_BAD_ESC);
        acc_nxt = '0;
        cnt_nxt = '0;
        ph_nxt  = '0;
        pv_nxt  = 1'b0;
      end
    end
  end

  // Result list: three flushed surrogate bytes first, then the tail.
  always_comb begin
    ent = '0;
    if (flush) begin
      ent[0]  = pend_enc.res[0];
      ent[1]  = pend_enc.res[1];
      ent[2]  = pend_enc.res[2];
      ent[3]  = tail.res[0];
      ent[4]  = tail.res[1];
      ent[5]  = tail.res[2];
      n_items = 3'(tail.n + 3'd3);
    end else begin
      ent[0]  = tail.res[0];
      ent[1]  = tail.res[1];
      ent[2]  = tail.res[2];
      ent[3]  = tail.res[3];
      n_items = tail.n;
    end
    last_idx = 3'(n_items - 3'd1);
  end

  // Handshake and retire control.
  assign in_ready  = !skid_v_r;
  assign in_fire   = in_valid && in_ready;
  assign out_load  = !out_valid_r || out_ready;
  assign consume   = main_v_r && ((n_items == 3'd0) || (out_load && idx_r == last_idx));
  assign main_free = !main_v_r || consume;

  // Input stage: holding register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (main_free) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_v_r) begin
        main_byte_r <= skid_byte_r;
        main_eot_r  <= skid_eot_r;
      end else begin
        main_byte_r <= in_byte;
        main_eot_r  <= in_end_of_text;
      end
    end
    if (in_fire && !main_free) begin
      skid_byte_r <= in_byte;
      skid_eot_r  <= in_end_of_text;
    end
  end

  // Scanner state commits when the held byte retires.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      acc_r  <= '0;
      cnt_r  <= '0;
      ph_r   <= '0;
      pv_r   <= 1'b0;
    end else if (consume) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      ph_r   <= ph_nxt;
      pv_r   <= pv_nxt;
    end
  end

  // Output register: one result of the list per cycle while out_load is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (out_load) begin
      out_valid_r <= main_v_r && (n_items != 3'd0);
      if (main_v_r && (n_items != 3'd0)) begin
        idx_r <= (idx_r == last_idx) ? 3'd0 : 3'(idx_r + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r      <= ent[idx_r];
      out_last_r <= (idx_r == last_idx);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_byte   = out_r.data_byte;
  assign out_byte_valid  = out_r.byte_valid;
  assign out_string_done = out_r.string_done;
  assign out_error_code  = out_r.error_code;
  assign out_last        = out_last_r;

endmodule

// ----- design/jsu_checker.sv -----
`include "json_string_unescape_utf8_macros.svh"

module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       in_end_of_text,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data_byte,
  input logic       out_byte_valid,
  input logic       out_string_done,
  input logic [2:0] out_error_code,
  input logic       out_last
);
  import jsu_pkg::*;

  // A waiting input transfer keeps its payload.
  `JSU_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
    in_valid && $stable(in_byte) && $stable(in_end_of_text),
    "input changed while stalled")

  // A stalled result transfer keeps its payload.
  `JSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_data_byte) && $stable(out_byte_valid) &&
    $stable(out_string_done) && $stable(out_error_code) && $stable(out_last),
    "result changed while stalled")

  // A byte result carries neither a done flag nor an error.
  `JSU_ASSERT_NOW(a_byte_clean, out_valid && out_byte_valid,
    !out_string_done && out_error_code == ERR_NONE, "byte result with status")

  // Done and error results carry no byte and end the list of their input.
  `JSU_ASSERT_NOW(a_status_last, out_valid && (out_string_done || out_error_code != ERR_NONE),
    !out_byte_valid && out_data_byte == 8'h00 && out_last, "status result malformed")

  // Every result carries a byte, a done flag or a known error.
  `JSU_ASSERT_NOW(a_result_kind, out_valid,
    (out_byte_valid || out_string_done || out_error_code != ERR_NONE) &&
    out_error_code <= ERR_UNTERM, "empty or unknown result")

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_byte         (in_byte),
  .in_end_of_text  (in_end_of_text),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_data_byte   (out_data_byte),
  .out_byte_valid  (out_byte_valid),
  .out_string_done (out_string_done),
  .out_error_code  (out_error_code),
  .out_last        (out_last)
);

// ----- tb/json_string_unescape_utf8_tb.sv -----
module json_string_unescape_utf8_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam int DIRECTED_ITEMS  = 29;
  localparam int ITEMS_PER_PHASE = 85;
  localparam int HOLD_CYCLES     = 64;
  localparam int STUCK_LIMIT     = 1000;
  localparam int SETTLE_CYCLES   = 10;

  // Expected decoder output: a software copy of the unescaper and a FIFO of
  // the bytes, done markers and error codes it predicts.
  class unescape_scoreboard;
    typedef struct {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       string_done;
      logic [2:0] error_code;
      logic       last;
    } out_item_t;

    mode_t       mode;
    logic [15:0] hex_acc;
    int unsigned hex_cnt;
    logic [9:0]  held_high;
    bit          held;
    out_item_t   step_q[$];
    out_item_t   decoded_q[$];
    int          errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      mode      = MODE_NORMAL;
      hex_acc   = '0;
      hex_cnt   = 0;
      held_high = '0;
      held      = 1'b0;
    endfunction

    function int hex_nibble(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b) - int'("0");
      if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
      if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
      return -1;
    endfunction

    function void emit(logic [7:0] data, bit bv, bit done, logic [2:0] err);
      out_item_t r;
      r.data_byte   = data;
      r.byte_valid  = bv;
      r.string_done = done;
      r.error_code  = err;
      r.last        = 1'b0;
      step_q = {step_q, r};
    endfunction

    // UTF-8 encoding of one code point.
    function void emit_code(logic [20:0] cp);
      if (cp < CP_2BYTE) begin
        emit(cp[7:0], 1'b1, 1'b0, ERR_NONE);
      end else if (cp < CP_3BYTE) begin
        emit({3'b110, cp[10:6]}, 1'b1, 1'b0, ERR_NONE);
        emit({2'b10, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
      end else if (cp < CP_4BYTE) begin
        emit({4'b1110, cp[15:12]}, 1'b1, 1'b0, ERR_NONE);
        emit({2'b10, cp[11:6]}, 1'b1, 1'b0, ERR_NONE);
        emit({2'b10, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
      end else begin
        emit({5'b11110, cp[20:18]}, 1'b1, 1'b0, ERR_NONE);
        emit({2'b10, cp[17:12]}, 1'b1, 1'b0, ERR_NONE);
        emit({2'b10, cp[11:6]}, 1'b1, 1'b0, ERR_NONE);
        emit({2'b10, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
      end
    endfunction

    // A held high surrogate that found no partner goes out as three bytes.
    function void flush_high();
      if (held) emit_code({5'b00000, SURR_HI_TAG, held_high});
      held      = 1'b0;
      held_high = '0;
    endfunction

    function void text_char(logic [7:0] b);
      mode = MODE_NORMAL;
      if (b == CH_QUOTE) begin
        emit(8'h00, 1'b0, 1'b1, ERR_NONE);
        restart();
      end else if (b == CH_BSLASH) begin
        mode = MODE_ESC;
      end else begin
        emit(b, 1'b1, 1'b0, ERR_NONE);
      end
    endfunction

    function void escape_char(logic [7:0] b);
      mode = MODE_NORMAL;
      case (b)
        CH_QUOTE:  emit(CH_QUOTE, 1'b1, 1'b0, ERR_NONE);
        CH_BSLASH: emit(CH_BSLASH, 1'b1, 1'b0, ERR_NONE);
        CH_SLASH:  emit(CH_SLASH, 1'b1, 1'b0, ERR_NONE);
        CH_LOW_B:  emit(CTL_BS, 1'b1, 1'b0, ERR_NONE);
        CH_LOW_F:  emit(CTL_FF, 1'b1, 1'b0, ERR_NONE);
        CH_LOW_N:  emit(CTL_LF, 1'b1, 1'b0, ERR_NONE);
        CH_LOW_R:  emit(CTL_CR, 1'b1, 1'b0, ERR_NONE);
        CH_LOW_T:  emit(CTL_HT, 1'b1, 1'b0, ERR_NONE);
        CH_LOW_U: begin
          mode    = MODE_HEX;
          hex_acc = '0;
          hex_cnt = 0;
        end
        default: begin
          emit(8'h00, 1'b0, 1'b0, ERR_BAD_ESC);
          restart();
        end
      endcase
    endfunction

    // Four hex digits are in: pair, hold or encode the code unit.
    function void end_code(logic [15:0] code);
      mode    = MODE_NORMAL;
      hex_acc = '0;
      hex_cnt = 0;
      if (held) begin
        if (code >= SURR_LO_MIN && code <= SURR_LO_MAX) begin
          emit_code(CP_4BYTE + {1'b0, held_high, code[9:0]});
          held      = 1'b0;
          held_high = '0;
          return;
        end
        flush_high();
      end
      if (code >= SURR_HI_MIN && code <= SURR_HI_MAX) begin
        held_high = code[9:0];
        held      = 1'b1;
        mode      = MODE_PEND;
        return;
      end
      emit_code({5'b00000, code});
    endfunction

    // Called once per accepted input transfer.
    function void take_byte(logic [7:0] b, bit eot);
      int         nib;
      logic [2:0] err;
      out_item_t  r;
      step_q.delete();
      if (eot) begin
        err = (mode == MODE_HEX) ? ERR_TRUNC_HEX : ERR_UNTERM;
        flush_high();
        emit(8'h00, 1'b0, 1'b0, err);
        restart();
      end else begin
        case (mode)
          MODE_ESC: escape_char(b);
          MODE_PEND: begin
            if (b == CH_BSLASH) begin
              mode = MODE_PEND_ESC;
            end else begin
              flush_high();
              text_char(b);
            end
          end
          MODE_PEND_ESC: begin
            if (b == CH_LOW_U) begin
              mode    = MODE_HEX;
              hex_acc = '0;
              hex_cnt = 0;
            end else begin
              flush_high();
              escape_char(b);
            end
          end
          MODE_HEX: begin
            nib = hex_nibble(b);
            if (nib < 0) begin
              flush_high();
              emit(8'h00, 1'b0, 1'b0, ERR_BAD_HEX);
              restart();
            end else begin
              hex_acc = {hex_acc[11:0], 4'(nib)};
              hex_cnt++;
              if (hex_cnt >= 4) end_code(hex_acc);
            end
          end
          default: text_char(b);
        endcase
      end
      foreach (step_q[i]) begin
        r         = step_q[i];
        r.last    = (i == step_q.size() - 1);
        decoded_q = {decoded_q, r};
      end
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    // Called once per accepted output transfer.
    function void check_output(logic [7:0] data, logic bv, logic done,
                               logic [2:0] err, logic last);
      out_item_t want;
      if (decoded_q.size() == 0) begin
        $error("unexpected result: data_byte=0x%0h byte_valid=%0b %s=%0b %s=%0d last=%0b",
               data, bv, "string_done", done, "error_code", err, last);
        errors++;
        return;
      end
      want = decoded_q.pop_front();
      compare_field("data_byte", want.data_byte, data);
      compare_field("byte_valid", 8'(want.byte_valid), 8'(bv));
      compare_field("string_done", 8'(want.string_done), 8'(done));
      compare_field("error_code", 8'(want.error_code), 8'(err));
      compare_field("last", 8'(want.last), 8'(last));
    endfunction
  endclass

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte        = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_byte_valid;
  logic       out_string_done;
  logic [2:0] out_error_code;
  logic       out_last;

  unescape_scoreboard sb = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int items_sent    = 0;
  bit hold_req      = 1'b0;
  int hold_left     = 0;
  int stuck_cycles  = 0;

  always #2 clk = ~clk;

  json_string_unescape_utf8 DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_byte   (out_data_byte),
    .out_byte_valid  (out_byte_valid),
    .out_string_done (out_string_done),
    .out_error_code  (out_error_code),
    .out_last        (out_last)
  );

  // Receiver: check each output transfer, then pick next cycle's ready.
  // A requested hold-off keeps ready low for a long stretch.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_output(out_data_byte, out_byte_valid, out_string_done,
                      out_error_code, out_last);
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: too many cycles without any transfer means the block hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] escape_letter(int i);
    case (i)
      0:       return CH_QUOTE;
      1:       return CH_BSLASH;
      2:       return CH_SLASH;
      3:       return CH_LOW_B;
      4:       return CH_LOW_F;
      5:       return CH_LOW_N;
      6:       return CH_LOW_R;
      default: return CH_LOW_T;
    endcase
  endfunction

  // One input transfer, with a random idle gap before it.
  task automatic send_item(input logic [7:0] b, input bit eot);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    sb.take_byte(b, eot);
    items_sent++;
  endtask

  task automatic send_escape_u(input logic [15:0] code);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_LOW_U, 1'b0);
    for (int i = 3; i >= 0; i--) send_item(hex_char(code[i*4 +: 4]), 1'b0);
  endtask

  // Drop valid and wait until every predicted result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.decoded_q.size() != 0);
  endtask

  // One random piece of a string body: mostly well-formed, some broken.
  task automatic send_token();
    int          pick;
    int          digits;
    logic [7:0]  b;
    logic [15:0] code;
    bit          ok;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_item(8'($urandom_range(255)), 1'b0);
    end else if (pick < 45) begin
      send_item(CH_BSLASH, 1'b0);
      send_item(escape_letter($urandom_range(7)), 1'b0);
    end else if (pick < 62) begin
      case ($urandom_range(3))
        0:       code = 16'($urandom_range(16'h7F));
        1:       code = 16'($urandom_range(16'h7FF, 16'h80));
        2:       code = 16'($urandom());
        default: code = 16'($urandom_range(SURR_LO_MAX, SURR_LO_MIN));
      endcase
      send_escape_u(code);
    end else if (pick < 72) begin
      // Surrogate pair.
      send_escape_u(16'($urandom_range(SURR_HI_MAX, SURR_HI_MIN)));
      send_escape_u(16'($urandom_range(SURR_LO_MAX, SURR_LO_MIN)));
    end else if (pick < 77) begin
      // High surrogate; whatever comes next decides its fate.
      send_escape_u(16'($urandom_range(SURR_HI_MAX, SURR_HI_MIN)));
    end else if (pick < 84) begin
      send_item(CH_QUOTE, 1'b0);
    end else if (pick < 88) begin
      send_item(8'($urandom()), 1'b1);
    end else if (pick < 91) begin
      // Backslash followed by a letter that is no escape.
      do begin
        b  = 8'($urandom());
        ok = (b != CH_LOW_U);
        for (int i = 0; i < 8; i++) if (b == escape_letter(i)) ok = 1'b0;
      end while (!ok);
      send_item(CH_BSLASH, 1'b0);
      send_item(b, 1'b0);
    end else begin
      // Hex escape cut short by a bad digit or by the end of text.
      digits = $urandom_range(3);
      send_item(CH_BSLASH, 1'b0);
      send_item(CH_LOW_U, 1'b0);
      repeat (digits) send_item(hex_char(4'($urandom())), 1'b0);
      if (pick < 95) begin
        do b = 8'($urandom()); while (sb.hex_nibble(b) >= 0);
        send_item(b, 1'b0);
      end else begin
        send_item(8'($urandom()), 1'b1);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: byte extremes, held and lone surrogates, errors, done.
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_escape_u(SURR_HI_MIN);
    // A second high surrogate releases the first and is held itself.
    send_escape_u(SURR_HI_MAX);
    // A plain byte releases the held high surrogate.
    send_item("q", 1'b0);
    send_escape_u(SURR_LO_MIN);
    send_item(CH_BSLASH, 1'b0);
    send_item("z", 1'b0);
    send_item(CH_QUOTE, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_LOW_U, 1'b0);
    send_item("7", 1'b0);
    send_item(8'hA5, 1'b1);

    // Random phases with different idle and stall mixes.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          // Long receiver hold-off while the sender keeps offering.
          hold_req      = 1'b1;
        end
        1: begin
          send_idle_pct = 58;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 58;
        end
        default: begin
          send_idle_pct = 29;
          stall_pct     = 29;
        end
      endcase
      while (items_sent < DIRECTED_ITEMS + (phase + 1) * ITEMS_PER_PHASE) send_token();
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/jsu_pkg.sv
design/json_string_unescape_utf8.sv
design/jsu_checker.sv
tb/json_string_unescape_utf8_tb.sv
